// ===== rtl/core/zsbe_pkg.sv =====
// zsbe_pkg: shared types and constants of the zlib stored-block encoder
// used by zsbe_front, zsbe_fifo, zsbe_back and zlib_stored_block_encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package zsbe_pkg;

  // largest stored block payload, up to 65535
  localparam logic [15:0] MAX_BLOCK = 16'd65535;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_STREAM_HDR = 2'd0,
    KIND_BLOCK_HDR  = 2'd1,
    KIND_PAYLOAD    = 2'd2,
    KIND_CHECKSUM   = 2'd3
  } kind_t;

  // back-end output sequencer phases
  typedef enum logic [3:0] {
    PH_START,
    PH_HDR0,
    PH_HDR1,
    PH_BH0,
    PH_BH1,
    PH_BH2,
    PH_BH3,
    PH_BH4,
    PH_PAY,
    PH_CK0,
    PH_CK1,
    PH_CK2,
    PH_CK3
  } phase_t;

  // one command per accepted input byte
  typedef struct packed {
    logic        hdr;        // emit stream header first
    logic        blk;        // emit a block header
    logic        blk_final;
    logic [15:0] blk_len;
    logic        pay;        // emit the payload byte
    logic [7:0]  data;
    logic        sum;        // emit checksum and end the stream
    logic [15:0] sum_high;
    logic [15:0] sum_low;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/zsbe_front.sv =====
// zsbe_front: accepts raw bytes, tracks message and block position and adler-32
// and turns each byte into one command for the back end; depends on zsbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsbe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_data,
  input  wire logic          q_full,
  output logic               in_ready,
  output logic               q_push,
  output zsbe_pkg::cmd_t     q_cmd
);
  import zsbe_pkg::*;

  logic [31:0] message_length;
  logic [31:0] bytes_taken, bytes_taken_next;
  logic [15:0] block_left, block_left_next;
  logic [15:0] sum_low, sum_low_next;
  logic [15:0] sum_high, sum_high_next;

  logic        is_empty, need_blk, done, rem_fits;
  logic [31:0] remaining, bt_inc;
  logic [15:0] chunk, left_base;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_new, hi_new;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    is_empty  = (message_length == 32'd0);
    need_blk  = (block_left == 16'd0);
    remaining = (message_length > bytes_taken) ? (message_length - bytes_taken) : 32'd1;
    rem_fits  = (remaining <= {16'd0, MAX_BLOCK});
    chunk     = rem_fits ? remaining[15:0] : MAX_BLOCK;
    left_base = need_blk ? chunk : block_left;
    bt_inc    = bytes_taken + 32'd1;
    done      = (bt_inc >= message_length);

    lo_sum = {1'b0, sum_low} + {9'd0, in_data};
    lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, sum_high} + {1'b0, lo_new};
    hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    if (is_empty) begin
      // whole empty stream: header, empty final block, checksum 1
      q_cmd.hdr       = 1'b1;
      q_cmd.blk       = 1'b1;
      q_cmd.blk_final = 1'b1;
      q_cmd.blk_len   = 16'd0;
      q_cmd.pay       = 1'b0;
      q_cmd.data      = in_data;
      q_cmd.sum       = 1'b1;
      q_cmd.sum_high  = 16'd0;
      q_cmd.sum_low   = 16'd1;
    end else begin
      q_cmd.hdr       = (bytes_taken == 32'd0) && need_blk;
      q_cmd.blk       = need_blk;
      q_cmd.blk_final = rem_fits;
      q_cmd.blk_len   = chunk;
      q_cmd.pay       = 1'b1;
      q_cmd.data      = in_data;
      q_cmd.sum       = done;
      q_cmd.sum_high  = hi_new;
      q_cmd.sum_low   = lo_new;
    end

    if (is_empty || done) begin
      bytes_taken_next = 32'd0;
      block_left_next  = 16'd0;
      sum_low_next     = 16'd1;
      sum_high_next    = 16'd0;
    end else begin
      bytes_taken_next = bt_inc;
      block_left_next  = left_base - 16'd1;
      sum_low_next     = lo_new;
      sum_high_next    = hi_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= 32'd0;
    end else if (cfg_we) begin
      message_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken <= 32'd0;
      block_left  <= 16'd0;
      sum_low     <= 16'd1;
      sum_high    <= 16'd0;
    end else if (q_push) begin
      bytes_taken <= bytes_taken_next;
      block_left  <= block_left_next;
      sum_low     <= sum_low_next;
      sum_high    <= sum_high_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/zsbe_fifo.sv =====
// zsbe_fifo: short command queue between front and back end
// depends on zsbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsbe_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire zsbe_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output zsbe_pkg::cmd_t      head
);
  import zsbe_pkg::*;

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count, count_next;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/zsbe_back.sv =====
// zsbe_back: expands queued commands into zlib stream bytes, one per cycle while
// out_ready does not stall, through a registered output stage; depends on zsbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsbe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire zsbe_pkg::cmd_t cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last
);
  import zsbe_pkg::*;

  phase_t     phase, phase_next, cur, after;
  logic       load;
  logic [7:0] byte_c;
  kind_t      kind_c;
  logic       last_c;

  function automatic phase_t tail_phase(cmd_t c);
    if (c.pay)      return PH_PAY;
    else if (c.sum) return PH_CK0;
    else            return PH_START;
  endfunction

  function automatic phase_t first_phase(cmd_t c);
    if (c.hdr)      return PH_HDR0;
    else if (c.blk) return PH_BH0;
    else            return tail_phase(c);
  endfunction

  assign load = !q_empty && (!out_valid || out_ready);
  assign cur  = (phase == PH_START) ? first_phase(cmd) : phase;

  // next state
  always_comb begin
    unique case (cur)
      PH_HDR0: after = PH_HDR1;
      PH_HDR1: after = cmd.blk ? PH_BH0 : tail_phase(cmd);
      PH_BH0:  after = PH_BH1;
      PH_BH1:  after = PH_BH2;
      PH_BH2:  after = PH_BH3;
      PH_BH3:  after = PH_BH4;
      PH_BH4:  after = tail_phase(cmd);
      PH_PAY:  after = cmd.sum ? PH_CK0 : PH_START;
      PH_CK0:  after = PH_CK1;
      PH_CK1:  after = PH_CK2;
      PH_CK2:  after = PH_CK3;
      default: after = PH_START;
    endcase
    phase_next = load ? after : phase;
  end

  assign q_pop = load && (after == PH_START);

  // outputs
  always_comb begin
    byte_c = 8'd0;
    kind_c = KIND_PAYLOAD;
    last_c = 1'b0;
    unique case (cur)
      PH_HDR0: begin byte_c = ZLIB_CMF;               kind_c = KIND_STREAM_HDR; end
      PH_HDR1: begin byte_c = ZLIB_FLG;               kind_c = KIND_STREAM_HDR; end
      PH_BH0:  begin byte_c = {7'd0, cmd.blk_final};  kind_c = KIND_BLOCK_HDR; end
      PH_BH1:  begin byte_c = cmd.blk_len[7:0];       kind_c = KIND_BLOCK_HDR; end
      PH_BH2:  begin byte_c = cmd.blk_len[15:8];      kind_c = KIND_BLOCK_HDR; end
      PH_BH3:  begin byte_c = ~cmd.blk_len[7:0];      kind_c = KIND_BLOCK_HDR; end
      PH_BH4:  begin byte_c = ~cmd.blk_len[15:8];     kind_c = KIND_BLOCK_HDR; end
      PH_PAY:  begin byte_c = cmd.data;               kind_c = KIND_PAYLOAD; end
      PH_CK0:  begin byte_c = cmd.sum_high[15:8];     kind_c = KIND_CHECKSUM; end
      PH_CK1:  begin byte_c = cmd.sum_high[7:0];      kind_c = KIND_CHECKSUM; end
      PH_CK2:  begin byte_c = cmd.sum_low[15:8];      kind_c = KIND_CHECKSUM; end
      PH_CK3:  begin
        byte_c = cmd.sum_low[7:0];
        kind_c = KIND_CHECKSUM;
        last_c = 1'b1;
      end
      default: begin byte_c = 8'd0;                   kind_c = KIND_PAYLOAD; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_c;
      out_kind <= kind_c;
      out_last <= last_c;
    end
  end

  a_last_is_checksum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_kind == KIND_CHECKSUM))
    else $error("end of stream on a non-checksum byte");

  a_pop_on_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> load)
    else $error("command retired without emitting a byte");

  a_phase_cleared: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (phase == PH_START))
    else $error("sequencer not back at start after retiring a command");

endmodule

`default_nettype wire

// ===== rtl/core/zlib_stored_block_encoder.sv =====
// zlib_stored_block_encoder: top level of the zlib stored-block encoder
// instantiates zsbe_front, zsbe_fifo and zsbe_back; depends on zsbe_pkg
//
// channel   | dir | handshake         | payload
// ----------+-----+-------------------+--------------------------------------------
// s_axis    | in  | tvalid / tready   | tdata[7:0] data_byte
// m_axis    | out | tvalid / tready   | tdata[7:0] out_byte, tuser[1:0] byte_kind,
//           |     |                   | tlast end_of_stream
// cfg       | in  | cfg_we            | cfg_wdata[31:0] message_length
//
// each accepted input byte becomes one command; the back end emits one stream byte
// per cycle while m_axis does not stall: a payload byte gives one stream byte, and one
// opening a stream or block or closing a stream adds header, block header or checksum
// the command queue holds four transactions, so input keeps flowing while a burst drains
// rst is synchronous, active high: clears the queue, the output stage and message state
// a stall on m_axis backs up into the queue and then drops s_tready
`timescale 1ns / 1ps
`default_nettype none

module zlib_stored_block_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,    // message_length
  // raw message bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
  // zlib stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,      // [7:0] out_byte
  output logic [1:0]       m_tuser,      // [1:0] byte_kind
  output logic             m_tlast       // end_of_stream
);
  import zsbe_pkg::*;

  // front to queue
  logic q_push, q_full, q_empty, q_pop;
  cmd_t push_cmd, head_cmd;

  // front: position tracking, adler-32 and command build
  zsbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // decoupling queue
  zsbe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  // back: byte sequencer with registered output
  zsbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .cmd       (head_cmd),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/zsbe_checker.sv =====
// zsbe_checker: watches the cfg, s_axis and m_axis channels of the encoder,
// predicts the zlib stream for each byte taken in and compares it with the output
// depends on zsbe_pkg
`timescale 1ns / 1ps

module zsbe_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int unsigned      fail_count,
  output int unsigned      due_count
);

  import zsbe_pkg::*;

  typedef struct packed {
    logic [7:0] val;
    kind_t      kind;
    logic       eos;
  } zbyte_t;

  zbyte_t      stream_due[$];
  logic [31:0] msg_len;
  logic [31:0] taken;
  logic [15:0] blk_left;
  logic [15:0] adler_a;
  logic [15:0] adler_b;

  task automatic due(input logic [7:0] v, input kind_t k, input logic e);
    zbyte_t item;
    item = '{val: v, kind: k, eos: e};
    stream_due.insert(stream_due.size(), item);
  endtask

  task automatic clear_message();
    taken    = '0;
    blk_left = '0;
    adler_a  = 16'd1;
    adler_b  = '0;
  endtask

  task automatic block_header(input logic [15:0] len, input logic is_last_blk);
    logic [15:0] nlen;
    nlen = ~len;
    due({7'd0, is_last_blk}, KIND_BLOCK_HDR, 1'b0);
    due(len[7:0], KIND_BLOCK_HDR, 1'b0);
    due(len[15:8], KIND_BLOCK_HDR, 1'b0);
    due(nlen[7:0], KIND_BLOCK_HDR, 1'b0);
    due(nlen[15:8], KIND_BLOCK_HDR, 1'b0);
  endtask

  task automatic adler_trailer(input logic [15:0] hi, input logic [15:0] lo);
    due(hi[15:8], KIND_CHECKSUM, 1'b0);
    due(hi[7:0], KIND_CHECKSUM, 1'b0);
    due(lo[15:8], KIND_CHECKSUM, 1'b0);
    due(lo[7:0], KIND_CHECKSUM, 1'b1);
  endtask

  // stream bytes caused by one raw byte
  task automatic encode_byte(input logic [7:0] d);
    logic [31:0] remaining;
    logic [31:0] chunk;
    logic [16:0] lo;
    logic [16:0] hi;
    if (msg_len == '0) begin
      // empty message: whole empty stream, data ignored
      due(ZLIB_CMF, KIND_STREAM_HDR, 1'b0);
      due(ZLIB_FLG, KIND_STREAM_HDR, 1'b0);
      block_header(16'd0, 1'b1);
      adler_trailer(16'd0, 16'd1);
      clear_message();
    end else begin
      if (taken == '0 && blk_left == '0) begin
        due(ZLIB_CMF, KIND_STREAM_HDR, 1'b0);
        due(ZLIB_FLG, KIND_STREAM_HDR, 1'b0);
      end
      if (blk_left == '0) begin
        // new block, up to MAX_BLOCK; if past the length: a final block of one byte
        remaining = (msg_len > taken) ? msg_len - taken : 32'd1;
        chunk     = (remaining < {16'd0, MAX_BLOCK}) ? remaining : {16'd0, MAX_BLOCK};
        block_header(chunk[15:0], chunk == remaining);
        blk_left = chunk[15:0];
      end
      due(d, KIND_PAYLOAD, 1'b0);
      blk_left = blk_left - 16'd1;
      taken    = taken + 32'd1;
      lo = ({1'b0, adler_a} + {9'd0, d}) % ADLER_MOD;
      hi = ({1'b0, adler_b} + lo) % ADLER_MOD;
      adler_a = lo[15:0];
      adler_b = hi[15:0];
      if (taken >= msg_len) begin
        adler_trailer(adler_b, adler_a);
        clear_message();
      end
    end
  endtask

  always @(posedge clk) begin : watch
    zbyte_t want;
    if (rst) begin
      stream_due.delete();
      msg_len = '0;
      fail_count = 0;
      clear_message();
    end else begin
      if (cfg_we) msg_len = cfg_wdata;
      if (s_tvalid && s_tready) encode_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (stream_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output, expected nothing, got byte %h kind %0d last %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = stream_due.pop_front();
          if (m_tdata !== want.val) begin
            fail_count++;
            $display("%0t: out_byte expected %h, got %h", $time, want.val, m_tdata);
          end
          if (m_tuser !== want.kind) begin
            fail_count++;
            $display("%0t: byte_kind expected %0d, got %0d", $time, want.kind, m_tuser);
          end
          if (m_tlast !== want.eos) begin
            fail_count++;
            $display("%0t: end_of_stream expected %b, got %b", $time, want.eos, m_tlast);
          end
        end
      end
    end
    due_count = stream_due.size();
  end

endmodule

// ===== verif/zlib_stored_block_encoder_tb.sv =====
// zlib_stored_block_encoder_tb: stimulus and verdict for the zlib stored-block encoder
// instantiates zlib_stored_block_encoder and zsbe_checker; depends on zsbe_pkg
`timescale 1ns / 1ps

module zlib_stored_block_encoder_tb;

  // cycles without any transaction before the run is given up
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 32;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;     // [7:0] data_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;            // [7:0] out_byte
  logic [1:0]  m_tuser;            // [1:0] byte_kind
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned send_idle_pct  = 38;
  int unsigned take_stall_pct = 81;
  int unsigned quiet_cycles   = 0;

  zlib_stored_block_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  zsbe_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver back-pressure, rate set per phase
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= take_stall_pct);
  end

  // watchdog: no transaction on any channel for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("zlib_stored_block_encoder_tb: done, errors");
        $finish;
      end
    end
  end

  // one raw byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the input until every predicted stream byte has come out;
  // the checker counts are read at the falling edge, clear of the update
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    @(posedge clk);
  endtask

  // message_length is only written with the block drained
  task automatic set_length(input logic [31:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // messages of random length; some run over into the next message,
  // some have the length rewritten part way through
  task automatic random_messages(input int unsigned quota);
    int unsigned sent;
    int unsigned n;
    int unsigned cut;
    int unsigned i;
    int unsigned fill;
    logic [31:0] len;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
      set_length(len);
      if (len == 0) n = $urandom_range(1, 3);
      else n = len + (($urandom_range(3) == 0) ? $urandom_range(1, len) : 0);
      cut  = ($urandom_range(5) == 0) ? $urandom_range(1, n) : 0;
      fill = $urandom_range(7);
      for (i = 0; i < n; i++) begin
        if (cut != 0 && i == cut) set_length(32'($urandom_range(1, 20)));
        case (fill)
          0:       send_byte(8'hFF);
          1:       send_byte(8'h00);
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
      sent += n;
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: sender idles now and then, receiver mostly stalls

    // length still at its reset value of zero: empty stream
    send_byte(8'h5A);

    // explicit empty message, data extremes ignored
    set_length(32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);

    // one-byte messages back to back
    set_length(32'd1);
    send_byte(8'h00);
    send_byte(8'hFF);

    // three bytes, then a fourth starts a new stream which is cut short
    // by shrinking the length to what it has already taken
    set_length(32'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    set_length(32'd1);
    send_byte(8'h3C);

    // length raised mid-message: block of two runs out, a second final
    // block covers the rest
    set_length(32'd2);
    send_byte(8'h81);
    set_length(32'd6);
    for (k = 0; k < 5; k++) send_byte(8'(8'h11 << k));

    // largest length: first block announced full size, not final;
    // ended by dropping the length
    set_length(32'hFFFF_FFFF);
    send_byte(8'h7E);
    send_byte(8'hE7);
    send_byte(8'h42);
    set_length(32'd2);
    send_byte(8'h24);

    random_messages(75);

    // phase two: sender mostly idle, receiver stalls now and then
    drain();
    send_idle_pct  = 81;
    take_stall_pct = 38;
    random_messages(75);

    // phase three: no idling at all
    drain();
    send_idle_pct  = 0;
    take_stall_pct = 0;
    random_messages(70);

    // a block that runs out, then a length already passed:
    // the next byte gets a final block of one byte and ends the stream
    set_length(32'd2);
    send_byte(8'h99);
    set_length(32'd6);
    send_byte(8'h66);
    set_length(32'd1);
    send_byte(8'hC3);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("zlib_stored_block_encoder_tb: done, clean");
    end else begin
      $display("zlib_stored_block_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/zsbe_pkg.sv
rtl/core/zsbe_front.sv
rtl/core/zsbe_fifo.sv
rtl/core/zsbe_back.sv
rtl/core/zlib_stored_block_encoder.sv
verif/zsbe_checker.sv
verif/zlib_stored_block_encoder_tb.sv
